// File: rtl/cruise_throttle_controller_top_defines.svh
// Assertion macros for the cruise throttle controller.
`ifndef CRUISE_THROTTLE_CONTROLLER_TOP_DEFINES_SVH
`define CRUISE_THROTTLE_CONTROLLER_TOP_DEFINES_SVH
`ifndef SYNTH
`define CTC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("ctc check failed");
`define CTC_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("ctc reset check failed");
`else
`define CTC_ASSERT(lbl, prop)
`define CTC_ASSERT_RST(lbl, prop)
`endif
`endif

// File: rtl/ctc_pkg.sv
// Types and constants shared by the cruise throttle controller.
package ctc_pkg;

  localparam int ThrW   = 7;
  localparam int StepW  = 4;
  localparam int EngW   = 10;
  localparam int SpeedW = 11;
  localparam int ErrW   = 12;
  localparam int IdxW   = 2;
  localparam int DataW  = 10;

  localparam logic [IdxW-1:0] REG_THROTTLE_MAX = 2'd0;
  localparam logic [IdxW-1:0] REG_GAS_STEP     = 2'd1;
  localparam logic [IdxW-1:0] REG_ENGAGE_SPEED = 2'd2;

  localparam logic [ThrW-1:0]  THROTTLE_MAX_RST = 7'd80;
  localparam logic [StepW-1:0] GAS_STEP_RST     = 4'd4;
  localparam logic [EngW-1:0]  ENGAGE_SPEED_RST = 10'd200;

  localparam logic signed [ErrW-1:0] ERR_HI  = 12'sd20;
  localparam logic signed [ErrW-1:0] ERR_MID = 12'sd10;
  localparam logic signed [ErrW-1:0] ERR_LO  = 12'sd4;

  localparam logic [StepW-1:0] ADJ_HI  = 4'd10;
  localparam logic [StepW-1:0] ADJ_MID = 4'd5;
  localparam logic [StepW-1:0] ADJ_LO  = 4'd1;

  typedef struct packed {
    logic                     engine_switch;
    logic                     top_gear_switch;
    logic                     gas_button;
    logic                     brake_button;
    logic                     cruise_button;
    logic signed [SpeedW-1:0] current_speed;
  } ctc_item_t;

  typedef struct packed {
    logic [ThrW-1:0]          throttle;
    logic                     engaged;
    logic signed [SpeedW-1:0] target;
  } ctc_state_t;

  typedef struct packed {
    logic [ThrW-1:0]  throttle_max;
    logic [StepW-1:0] gas_step;
    logic [EngW-1:0]  engage_speed;
  } ctc_cfg_t;

endpackage

// File: rtl/cruise_throttle_controller_top.sv
// A word goes through the input register, which feeds the state update directly,
// and the result register. Throughput: one word per cycle while out_stall is low.
// The output register frees the input side while a result waits to be taken.
// Reset: synchronous, active high; clears throttle, cruise flag, target and valid flags,
// and loads throttle_max 80, gas_step 4, engage_speed 200. cfg_ready is always high.
`include "cruise_throttle_controller_top_defines.svh"
module cruise_throttle_controller_top
  import ctc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     engine_switch,
  input  logic                     top_gear_switch,
  input  logic                     gas_button,
  input  logic                     brake_button,
  input  logic                     cruise_button,
  input  logic signed [SpeedW-1:0] current_speed,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [ThrW-1:0]          throttle_out,
  output logic                     cruise_active,
  output logic signed [SpeedW-1:0] target_speed,
  output logic                     engine_running,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [IdxW-1:0]          cfg_index,
  input  logic [DataW-1:0]         cfg_data
);

  ctc_cfg_t   cfg;
  ctc_state_t state;
  ctc_state_t state_next;
  ctc_item_t  s1_item;
  logic       s1_valid;
  logic       out_ready;
  logic       adv;
  logic       step_running;

  assign cfg_ready = 1'b1;
  assign out_ready = !out_valid || !out_stall;
  assign adv       = s1_valid && out_ready;
  assign in_stall  = s1_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.throttle_max <= THROTTLE_MAX_RST;
      cfg.gas_step     <= GAS_STEP_RST;
      cfg.engage_speed <= ENGAGE_SPEED_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_THROTTLE_MAX: cfg.throttle_max <= cfg_data[ThrW-1:0];
        REG_GAS_STEP:     cfg.gas_step     <= cfg_data[StepW-1:0];
        REG_ENGAGE_SPEED: cfg.engage_speed <= cfg_data[EngW-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_item.engine_switch   <= engine_switch;
      s1_item.top_gear_switch <= top_gear_switch;
      s1_item.gas_button      <= gas_button;
      s1_item.brake_button    <= brake_button;
      s1_item.cruise_button   <= cruise_button;
      s1_item.current_speed   <= current_speed;
    end
  end

  ctc_step u_step (
    .item       (s1_item),
    .state      (state),
    .cfg        (cfg),
    .state_next (state_next),
    .running    (step_running)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (adv) begin
        state <= state_next;
      end
      if (out_ready) begin
        out_valid <= s1_valid;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (adv) begin
      throttle_out   <= state_next.throttle;
      cruise_active  <= state_next.engaged;
      target_speed   <= state_next.target;
      engine_running <= step_running;
    end
  end

  `CTC_ASSERT_RST(a_rst_empty, rst |=> !out_valid && !s1_valid)
  `CTC_ASSERT(a_idle_hold, adv && !step_running |=> $stable(state))
  `CTC_ASSERT(a_tgt_clear, !state.engaged |-> state.target == '0)
  `CTC_ASSERT(a_tgt_nonneg, state.engaged |-> !state.target[SpeedW-1])
  `CTC_ASSERT(a_stall_full, in_stall |-> s1_valid && out_valid)

endmodule

// File: rtl/ctc_step.sv
// Next-state logic for one control period of the cruise throttle controller.
module ctc_step
  import ctc_pkg::*;
(
  input  ctc_item_t  item,
  input  ctc_state_t state,
  input  ctc_cfg_t   cfg,
  output ctc_state_t state_next,
  output logic       running
);

  logic [ThrW:0]            gas_sum;
  logic [ThrW-1:0]          thr_gas;
  logic [ThrW-1:0]          thr_brk;
  logic                     engage;
  logic                     drop;
  logic                     eng_mid;
  logic                     eng_new;
  logic signed [SpeedW-1:0] tgt_mid;
  logic signed [SpeedW-1:0] tgt_new;
  logic signed [ErrW-1:0]   err;
  logic [StepW-1:0]         adj;
  logic                     adj_up;
  logic                     adj_dn;
  logic [ThrW:0]            up_sum;
  logic [ThrW-1:0]          thr_up;
  logic [ThrW-1:0]          thr_dn;
  logic [ThrW-1:0]          thr_new;

  assign running = item.engine_switch || (item.current_speed != '0);

  assign gas_sum = {1'b0, state.throttle} + {{(ThrW+1-StepW){1'b0}}, cfg.gas_step};
  assign thr_gas = !item.gas_button ? state.throttle :
                   (gas_sum >= {1'b0, cfg.throttle_max}) ? cfg.throttle_max :
                   gas_sum[ThrW-1:0];
  assign thr_brk = item.brake_button ? '0 : thr_gas;

  assign engage  = item.cruise_button &&
                   (item.current_speed >= $signed({1'b0, cfg.engage_speed}));
  assign eng_mid = engage || state.engaged;
  assign tgt_mid = (engage && !state.engaged) ? item.current_speed : state.target;
  assign drop    = item.gas_button || item.brake_button || !item.top_gear_switch;
  assign eng_new = drop ? 1'b0 : eng_mid;
  assign tgt_new = drop ? '0 : tgt_mid;

  assign err = {item.current_speed[SpeedW-1], item.current_speed}
             - {tgt_new[SpeedW-1], tgt_new};

  always_comb begin
    adj    = '0;
    adj_up = 1'b0;
    adj_dn = 1'b0;
    if (err >= ERR_HI) begin
      adj_dn = 1'b1;
      adj    = ADJ_HI;
    end else if (err >= ERR_MID) begin
      adj_dn = 1'b1;
      adj    = ADJ_MID;
    end else if (err >= ERR_LO) begin
      adj_dn = 1'b1;
      adj    = ADJ_LO;
    end else if (err <= -ERR_HI) begin
      adj_up = 1'b1;
      adj    = ADJ_HI;
    end else if (err <= -ERR_MID) begin
      adj_up = 1'b1;
      adj    = ADJ_MID;
    end else if (err <= -ERR_LO) begin
      adj_up = 1'b1;
      adj    = ADJ_LO;
    end
  end

  assign up_sum = {1'b0, thr_brk} + {{(ThrW+1-StepW){1'b0}}, adj};
  assign thr_up = (up_sum >= {1'b0, cfg.throttle_max}) ? cfg.throttle_max
                                                        : up_sum[ThrW-1:0];
  assign thr_dn = (thr_brk <= {{(ThrW-StepW){1'b0}}, adj}) ? '0
                : thr_brk - {{(ThrW-StepW){1'b0}}, adj};

  always_comb begin
    thr_new = thr_brk;
    if (eng_new && adj_dn) begin
      thr_new = thr_dn;
    end else if (eng_new && adj_up) begin
      thr_new = thr_up;
    end
  end

  always_comb begin
    state_next = state;
    if (running) begin
      state_next.throttle = thr_new;
      state_next.engaged  = eng_new;
      state_next.target   = tgt_new;
    end
  end

endmodule

// File: sim/ctc_checker.sv
// Checker for the cruise throttle controller: watches the channels, predicts each period, compares.
module ctc_checker
  import ctc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic                     engine_switch,
  input  logic                     top_gear_switch,
  input  logic                     gas_button,
  input  logic                     brake_button,
  input  logic                     cruise_button,
  input  logic signed [SpeedW-1:0] current_speed,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic [ThrW-1:0]          throttle_out,
  input  logic                     cruise_active,
  input  logic signed [SpeedW-1:0] target_speed,
  input  logic                     engine_running,
  input  logic                     cfg_valid,
  input  logic                     cfg_ready,
  input  logic [IdxW-1:0]          cfg_index,
  input  logic [DataW-1:0]         cfg_data,
  output int                       mismatch_count,
  output int                       periods_in_flight
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [ThrW-1:0]          throttle;
    logic                     engaged;
    logic signed [SpeedW-1:0] target;
    logic                     running;
  } period_result_t;

  logic [ThrW-1:0]  thr_max;
  logic [StepW-1:0] gas_step;
  logic [EngW-1:0]  engage_speed;
  int               throttle_lvl;
  logic             engaged;
  int               target;
  period_result_t   expected_periods[$];

  function automatic int raise_thr(int t, int inc);
    int s;
    s = t + inc;
    return (s >= int'(thr_max)) ? int'(thr_max) : s;
  endfunction

  function automatic int lower_thr(int t, int dec);
    return (t <= dec) ? 0 : t - dec;
  endfunction

  function automatic period_result_t next_period(ctc_item_t w);
    int             speed;
    int             err;
    logic           running;
    period_result_t r;
    speed   = $signed(w.current_speed);
    running = w.engine_switch || speed != 0;
    if (running) begin
      if (w.gas_button) throttle_lvl = raise_thr(throttle_lvl, int'(gas_step));
      if (w.brake_button) throttle_lvl = 0;
      if (w.cruise_button && speed >= int'(engage_speed)) begin
        if (!engaged) target = speed;
        engaged = 1'b1;
      end
      if (w.gas_button || w.brake_button || !w.top_gear_switch) begin
        engaged = 1'b0;
        target  = 0;
      end
      if (engaged) begin
        err = speed - target;
        if (err >= int'(ERR_HI)) throttle_lvl = lower_thr(throttle_lvl, int'(ADJ_HI));
        else if (err >= int'(ERR_MID)) throttle_lvl = lower_thr(throttle_lvl, int'(ADJ_MID));
        else if (err >= int'(ERR_LO)) throttle_lvl = lower_thr(throttle_lvl, int'(ADJ_LO));
        else if (err <= -int'(ERR_HI)) throttle_lvl = raise_thr(throttle_lvl, int'(ADJ_HI));
        else if (err <= -int'(ERR_MID)) throttle_lvl = raise_thr(throttle_lvl, int'(ADJ_MID));
        else if (err <= -int'(ERR_LO)) throttle_lvl = raise_thr(throttle_lvl, int'(ADJ_LO));
      end
      throttle_lvl = throttle_lvl & 127;
    end
    r.throttle = throttle_lvl[ThrW-1:0];
    r.engaged  = engaged;
    r.target   = target[SpeedW-1:0];
    r.running  = running;
    return r;
  endfunction

  always @(posedge clk) begin
    period_result_t want;
    period_result_t got;
    if (rst) begin
      thr_max      = THROTTLE_MAX_RST;
      gas_step     = GAS_STEP_RST;
      engage_speed = ENGAGE_SPEED_RST;
      throttle_lvl = 0;
      engaged      = 1'b0;
      target       = 0;
      expected_periods.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_THROTTLE_MAX: thr_max = cfg_data[ThrW-1:0];
          REG_GAS_STEP:     gas_step = cfg_data[StepW-1:0];
          REG_ENGAGE_SPEED: engage_speed = cfg_data[EngW-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        got = '{throttle_out, cruise_active, target_speed, engine_running};
        if (expected_periods.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: unexpected word thr=%0d cruise=%0b tgt=%0d run=%0b", $realtime,
                     got.throttle, got.engaged, got.target, got.running);
        end else begin
          want = expected_periods.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("%0t: exp thr=%0d cruise=%0b tgt=%0d run=%0b, got thr=%0d cruise=%0b tgt=%0d run=%0b",
                       $realtime, want.throttle, want.engaged, want.target, want.running,
                       got.throttle, got.engaged, got.target, got.running);
          end
        end
      end
      if (in_valid && !in_stall)
        expected_periods.push_back(next_period('{engine_switch, top_gear_switch, gas_button,
                                                 brake_button, cruise_button, current_speed}));
    end
    periods_in_flight = expected_periods.size();
  end

endmodule

// File: sim/tb_cruise_throttle_controller_top.sv
// Testbench top for the cruise throttle controller: clock, reset, stimulus and verdict.
module tb_cruise_throttle_controller_top
  import ctc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [IdxW-1:0] REG_UNUSED = 2'd3;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HALF, STALL_HEAVY} stall_mode_t;

  logic                     clk;
  logic                     rst;
  logic                     in_valid;
  logic                     in_stall;
  logic                     engine_switch;
  logic                     top_gear_switch;
  logic                     gas_button;
  logic                     brake_button;
  logic                     cruise_button;
  logic signed [SpeedW-1:0] current_speed;
  logic                     out_valid;
  logic                     out_stall;
  logic [ThrW-1:0]          throttle_out;
  logic                     cruise_active;
  logic signed [SpeedW-1:0] target_speed;
  logic                     engine_running;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [IdxW-1:0]          cfg_index;
  logic [DataW-1:0]         cfg_data;
  int                       mismatch_count;
  int                       periods_in_flight;

  logic [EngW-1:0] engage_now;
  int              words_sent;
  int              burst_left;
  logic            want_hold;

  cruise_throttle_controller_top dut (.*);
  ctc_checker checker_i (.*);

  initial clk = 1'b0;
  always #1 clk = ~clk;

  initial begin
    #2_000_000;
    $display("tb_cruise_throttle_controller_top failed");
    $finish;
  end

  initial begin
    stall_mode_t mode;
    int          seg_left;
    int          hold_left;
    out_stall = 1'b0;
    seg_left  = 0;
    hold_left = 0;
    mode      = STALL_NONE;
    forever begin
      @(negedge clk);
      if (want_hold) begin
        want_hold = 1'b0;
        hold_left = 80;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall = 1'b1;
      end else begin
        if (seg_left == 0) begin
          mode     = stall_mode_t'($urandom_range(0, 3));
          seg_left = $urandom_range(4, 64);
        end
        seg_left--;
        case (mode)
          STALL_NONE:  out_stall = 1'b0;
          STALL_LIGHT: out_stall = ($urandom_range(0, 3) == 0);
          STALL_HALF:  out_stall = ($urandom_range(0, 1) != 0);
          default:     out_stall = ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  function automatic ctc_item_t period_word(bit eng, bit top, bit gas, bit brk, bit cru,
                                            int speed);
    ctc_item_t w;
    w.engine_switch   = eng;
    w.top_gear_switch = top;
    w.gas_button      = gas;
    w.brake_button    = brk;
    w.cruise_button   = cru;
    w.current_speed   = speed[SpeedW-1:0];
    return w;
  endfunction

  function automatic ctc_item_t noise_word();
    int speed;
    case ($urandom_range(0, 4))
      0: speed = 0;
      1: speed = $urandom;
      2: speed = int'(engage_now) + $urandom_range(0, 8) - 4;
      3: speed = $urandom_range(0, 1023);
      default: speed = -int'($urandom_range(1, 1024));
    endcase
    return period_word($urandom_range(0, 7) != 0, $urandom_range(0, 7) != 0,
                       $urandom_range(0, 3) == 0, $urandom_range(0, 7) == 0,
                       $urandom_range(0, 2) == 0, speed);
  endfunction

  task automatic send_word(ctc_item_t w);
    @(negedge clk);
    in_valid        = 1'b1;
    engine_switch   = w.engine_switch;
    top_gear_switch = w.top_gear_switch;
    gas_button      = w.gas_button;
    brake_button    = w.brake_button;
    cruise_button   = w.cruise_button;
    current_speed   = w.current_speed;
    do @(posedge clk); while (in_stall);
    words_sent++;
  endtask

  task automatic offer(ctc_item_t w);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    send_word(w);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (periods_in_flight != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [IdxW-1:0] idx, logic [DataW-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_ENGAGE_SPEED) engage_now = data[EngW-1:0];
  endtask

  task automatic set_config(logic [DataW-1:0] thr, logic [DataW-1:0] step,
                            logic [DataW-1:0] eng);
    write_reg(REG_THROTTLE_MAX, thr);
    write_reg(REG_GAS_STEP, step);
    write_reg(REG_ENGAGE_SPEED, eng);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic cruise_run();
    int base;
    int speed;
    base = $urandom_range(1023, engage_now);
    offer(period_word(1, 1, 0, 0, 1, base));
    repeat ($urandom_range(4, 24)) begin
      speed = base + int'($urandom_range(0, 60)) - 30;
      if (speed > 1023) speed = 1023;
      offer(period_word($urandom_range(0, 15) != 0, $urandom_range(0, 19) != 0,
                        $urandom_range(0, 24) == 0, $urandom_range(0, 24) == 0,
                        $urandom_range(0, 7) == 0, speed));
    end
  endtask

  task automatic gas_run(int len);
    repeat (len)
      offer(period_word(1, $urandom_range(0, 1), 1, 0, $urandom_range(0, 3) == 0,
                        $urandom_range(0, 1023)));
  endtask

  task automatic run_phase(int n);
    int start;
    int pick;
    start = words_sent;
    while (words_sent - start < n) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) cruise_run();
      else if (pick < 8) gas_run($urandom_range(3, 16));
      else repeat ($urandom_range(1, 8)) offer(noise_word());
    end
  endtask

  initial begin
    rst             = 1'b1;
    in_valid        = 1'b0;
    engine_switch   = 1'b0;
    top_gear_switch = 1'b0;
    gas_button      = 1'b0;
    brake_button    = 1'b0;
    cruise_button   = 1'b0;
    current_speed   = '0;
    cfg_valid       = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    engage_now      = ENGAGE_SPEED_RST;
    words_sent      = 0;
    burst_left      = 0;
    want_hold       = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    offer(period_word(0, 0, 1, 0, 0, 0));
    offer(period_word(0, 1, 1, 0, 0, 5));
    offer(period_word(1, 1, 1, 0, 0, 0));
    offer(period_word(1, 1, 1, 0, 0, 0));
    offer(period_word(1, 1, 0, 1, 0, 0));
    offer(period_word(1, 1, 1, 1, 0, 0));
    offer(period_word(1, 1, 1, 0, 0, 100));
    offer(period_word(1, 1, 1, 0, 0, 100));
    offer(period_word(1, 1, 1, 0, 0, 100));
    offer(period_word(1, 1, 0, 0, 1, 199));
    offer(period_word(1, 1, 0, 0, 1, -1024));
    offer(period_word(1, 1, 0, 0, 1, 200));
    offer(period_word(1, 1, 0, 0, 1, 250));
    offer(period_word(1, 1, 0, 0, 0, 225));
    offer(period_word(1, 1, 0, 0, 0, 180));
    offer(period_word(1, 1, 0, 0, 0, 190));
    offer(period_word(1, 1, 0, 0, 0, 196));
    offer(period_word(1, 1, 0, 0, 0, 197));
    offer(period_word(1, 1, 0, 0, 0, 203));
    offer(period_word(1, 1, 0, 0, 0, 204));
    offer(period_word(1, 1, 0, 0, 0, 210));
    offer(period_word(0, 1, 0, 0, 0, 0));
    offer(period_word(1, 0, 0, 0, 0, 210));
    offer(period_word(1, 1, 0, 0, 1, 1023));
    offer(period_word(1, 1, 1, 0, 0, 1023));
    offer(period_word(1, 1, 0, 0, 1, -1));
    drain();

    set_config(127, 15, 0);
    want_hold = 1'b1;
    run_phase(95);
    drain();
    run_phase(95);
    gas_run(12);
    drain();

    set_config(40, 3, 500);
    run_phase(180);
    drain();

    set_config(0, 0, 1023);
    run_phase(150);
    drain();

    write_reg(REG_UNUSED, DataW'($urandom_range(0, 1023)));
    repeat (2) begin
      set_config(DataW'($urandom_range(0, 1023)), DataW'($urandom_range(0, 1023)),
                 DataW'($urandom_range(0, 1023)));
      run_phase(180);
      drain();
    end

    set_config(80, 4, 200);
    run_phase(180);
    drain();

    repeat (4) @(negedge clk);
    if (mismatch_count == 0 && periods_in_flight == 0)
      $display("tb_cruise_throttle_controller_top passed");
    else
      $display("tb_cruise_throttle_controller_top failed");
    $finish;
  end

endmodule
